FILE: rtl/ltbp_pkg.sv
// shared types and constants for the local two-level branch predictor
package ltbp_pkg;

    localparam int ADDR_W     = 32;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;
    localparam int CTR_W      = 2;

    localparam logic [CTR_W-1:0] CTR_MIN = 2'd0;
    localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;

    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic ctr_read;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_update;
        logic out_stall;
    } status_t;

endpackage

FILE: rtl/ltbp_ctrl.sv
// sequencer for clearing, lookup and commit of one transaction at a time
module ltbp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ltbp_pkg::status_t status,
    output ltbp_pkg::cmd_t    cmd
);

    ltbp_pkg::state_t state_reg;
    ltbp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ltbp_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        unique case (state_reg)
            ltbp_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = ltbp_pkg::ST_IDLE;
                end
            end
            ltbp_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ltbp_pkg::ST_LOOKUP;
                end
            end
            ltbp_pkg::ST_LOOKUP: begin
                // history word is ready, fetch its counter
                cmd.ctr_read = 1'b1;
                state_next   = ltbp_pkg::ST_COMMIT;
            end
            ltbp_pkg::ST_COMMIT: begin
                // a prediction waits here until the output register is free
                if (status.is_update || !status.out_stall) begin
                    cmd.commit = 1'b1;
                    state_next = ltbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ltbp_pkg::ST_CLEAR;
            end
        endcase
    end

    a_capture_to_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> state_reg == ltbp_pkg::ST_LOOKUP)
        else $error("capture not followed by lookup");

    a_lookup_to_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ltbp_pkg::ST_LOOKUP |=> state_reg == ltbp_pkg::ST_COMMIT)
        else $error("lookup not followed by commit");

    a_clear_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_step && status.clear_last |=> state_reg == ltbp_pkg::ST_IDLE)
        else $error("clearing pass did not end in idle");

endmodule

FILE: rtl/ltbp_dpath.sv
// history and counter memories, item registers and output register
module ltbp_dpath #(
    parameter int INDEX_BITS   = 6,
    parameter int HISTORY_BITS = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ltbp_pkg::cmd_t                 cmd,
    output ltbp_pkg::status_t              status,
    input  logic [ltbp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ltbp_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int HIST_DEPTH = 1 << INDEX_BITS;
    localparam int CTR_DEPTH  = 1 << HISTORY_BITS;
    localparam int CLR_W      = (INDEX_BITS > HISTORY_BITS) ? INDEX_BITS : HISTORY_BITS;

    logic [HISTORY_BITS-1:0]    hist_mem [HIST_DEPTH];
    logic [ltbp_pkg::CTR_W-1:0] ctr_mem  [CTR_DEPTH];

    logic [CLR_W-1:0]           clr_addr_reg;
    logic                       kind_reg;
    logic [INDEX_BITS-1:0]      idx_reg;
    logic                       outcome_reg;
    logic [HISTORY_BITS-1:0]    hist_rd_reg;
    logic [ltbp_pkg::CTR_W-1:0] ctr_rd_reg;
    logic                       pred_reg;
    logic                       m_tvalid_reg;
    logic                       m_tvalid_next;

    logic [ltbp_pkg::CTR_W-1:0] ctr_next;
    logic [HISTORY_BITS-1:0]    hist_next;
    logic [HISTORY_BITS:0]      hist_wide;
    logic                       do_update;

    assign do_update = cmd.commit && (kind_reg == ltbp_pkg::KIND_UPDATE);

    // saturating step toward the outcome
    always_comb begin
        ctr_next = ctr_rd_reg;
        if (outcome_reg) begin
            if (ctr_rd_reg != ltbp_pkg::CTR_MAX) begin
                ctr_next = ctr_rd_reg + 2'd1;
            end
        end else begin
            if (ctr_rd_reg != ltbp_pkg::CTR_MIN) begin
                ctr_next = ctr_rd_reg - 2'd1;
            end
        end
    end

    assign hist_wide = {hist_rd_reg, outcome_reg};
    assign hist_next = hist_wide[HISTORY_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_addr_reg <= clr_addr_reg + CLR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg    <= s_tuser;
            idx_reg     <= s_tdata[INDEX_BITS-1:0];
            outcome_reg <= s_tdata[ltbp_pkg::ADDR_W];
        end
    end

    // history memory: one read port, one write port
    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            hist_mem[clr_addr_reg[INDEX_BITS-1:0]] <= '0;
        end else if (do_update) begin
            hist_mem[idx_reg] <= hist_next;
        end
        if (cmd.capture) begin
            hist_rd_reg <= hist_mem[s_tdata[INDEX_BITS-1:0]];
        end
    end

    // counter memory, indexed by the history from before the shift
    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            ctr_mem[clr_addr_reg[HISTORY_BITS-1:0]] <= '0;
        end else if (do_update) begin
            ctr_mem[hist_rd_reg] <= ctr_next;
        end
        if (cmd.ctr_read) begin
            ctr_rd_reg <= ctr_mem[hist_rd_reg];
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (cmd.commit && (kind_reg == ltbp_pkg::KIND_PREDICT)) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && (kind_reg == ltbp_pkg::KIND_PREDICT)) begin
            pred_reg <= ctr_rd_reg[ltbp_pkg::CTR_W-1];
        end
    end

    assign m_tvalid          = m_tvalid_reg;
    assign m_tdata           = {{(ltbp_pkg::M_TDATA_W-1){1'b0}}, pred_reg};
    assign status.clear_last = &clr_addr_reg;
    assign status.is_update  = kind_reg;
    assign status.out_stall  = m_tvalid_reg && !m_tready;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && (kind_reg == ltbp_pkg::KIND_PREDICT)
            |-> !(m_tvalid_reg && !m_tready))
        else $error("prediction committed over a pending result");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && (kind_reg == ltbp_pkg::KIND_PREDICT) |=> m_tvalid_reg)
        else $error("committed prediction not presented");

    a_clear_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_step |-> !cmd.capture && !cmd.commit)
        else $error("item activity during clearing pass");

endmodule

FILE: rtl/local_two_level_branch_predictor.sv
// top level of the local two-level (PAg) branch predictor
//
// channel  dir  handshake            payload
// s_       in   s_tvalid / s_tready  s_tuser: kind; s_tdata: branch_address, outcome
// m_       out  m_tvalid / m_tready  m_tdata: predict_taken
//
// each transaction passes through these steps: accept with history read, counter read,
// then commit of the counter and history writes or the prediction.
// the two dependent memory reads set this order; no transaction overlaps another.
// after reset a clearing pass over max(2^INDEX_BITS, 2^HISTORY_BITS) addresses
// zeroes both memories; s_tready stays low meanwhile.
// a prediction waits in the commit step while the output register is held.
module local_two_level_branch_predictor #(
    parameter int INDEX_BITS   = 6,
    parameter int HISTORY_BITS = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] branch_address, [32] outcome, [39:33] zero
    input  logic [ltbp_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] kind
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] predict_taken, [7:1] zero
    output logic [ltbp_pkg::M_TDATA_W-1:0] m_tdata
);

    ltbp_pkg::cmd_t    cmd;
    ltbp_pkg::status_t status;

    ltbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ltbp_dpath #(
        .INDEX_BITS   (INDEX_BITS),
        .HISTORY_BITS (HISTORY_BITS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: test/tb.sv
// self-checking testbench for the local two-level (pag) branch predictor
module tb;
    import ltbp_pkg::*;

    localparam int INDEX_BITS   = 6;
    localparam int HISTORY_BITS = 10;
    localparam int HIST_ENTRIES = 1 << INDEX_BITS;
    localparam int CTR_ENTRIES  = 1 << HISTORY_BITS;
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int WATCHDOG     = 6000;

    // per-branch histories and shared counters, plus the predictions still owed
    class pag_tables;
        logic [HISTORY_BITS-1:0] histories [HIST_ENTRIES];
        logic [CTR_W-1:0]        counters  [CTR_ENTRIES];
        logic                    predictions_due [$];
        int                      errors;
        int                      accepted;

        function new();
            foreach (histories[i]) histories[i] = '0;
            foreach (counters[i]) counters[i] = CTR_MIN;
            errors   = 0;
            accepted = 0;
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task note_branch(input logic kind, input logic [ADDR_W-1:0] addr,
                         input logic outcome);
            logic [INDEX_BITS-1:0]   idx;
            logic [HISTORY_BITS-1:0] hist;
            logic [CTR_W-1:0]        ctr;
            idx  = addr[INDEX_BITS-1:0];
            hist = histories[idx];
            ctr  = counters[hist];
            accepted++;
            if (kind == KIND_PREDICT) begin
                // upper counter bit set means weak or strong taken
                predictions_due.push_back(ctr[1]);
            end else begin
                if (outcome && ctr != CTR_MAX)
                    ctr = ctr + 2'd1;
                else if (!outcome && ctr != CTR_MIN)
                    ctr = ctr - 2'd1;
                counters[hist] = ctr;
                histories[idx] = {hist[HISTORY_BITS-2:0], outcome};
            end
        endtask

        task check_prediction(input logic [M_TDATA_W-1:0] data);
            logic want;
            if (predictions_due.size() == 0) begin
                report($sformatf("unexpected result transaction, tdata 0x%0h", data));
            end else begin
                want = predictions_due.pop_front();
                if (data[0] !== want)
                    report($sformatf("predict_taken got %b want %b", data[0], want));
            end
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    pag_tables tables = new();

    local_two_level_branch_predictor #(
        .INDEX_BITS   (INDEX_BITS),
        .HISTORY_BITS (HISTORY_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_branch(input logic kind, input logic [ADDR_W-1:0] addr,
                               input logic outcome);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W-ADDR_W-1){1'b0}}, outcome, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tables.note_branch(kind, addr, outcome);
    endtask

    // sender
    initial begin
        logic [INDEX_BITS-1:0] hot [6];
        logic                  toggle [HIST_ENTRIES];
        logic [ADDR_W-1:0]     addr;
        logic [INDEX_BITS-1:0] idx;
        logic                  kind;
        logic                  outcome;
        int                    sent;
        int                    burst;
        int                    gap;

        foreach (hot[i]) hot[i] = INDEX_BITS'($urandom_range(0, HIST_ENTRIES - 1));
        foreach (toggle[i]) toggle[i] = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: fresh counters, all-ones address, saturation at the lower end,
        // upper address bits ignored, outcome ignored on predict
        send_branch(KIND_PREDICT, 32'h0000_0000, 1'b1);
        send_branch(KIND_PREDICT, 32'hFFFF_FFFF, 1'b0);
        for (int i = 0; i < 12; i++)
            send_branch(KIND_UPDATE, 32'hFFFF_FFC5 ^ (i << 12), 1'b1);
        send_branch(KIND_PREDICT, 32'h0000_0005, 1'b0);
        for (int i = 0; i < 5; i++)
            send_branch(KIND_UPDATE, 32'h4000_0005, 1'b0);
        send_branch(KIND_PREDICT, 32'h8000_0045, 1'b1);
        send_branch(KIND_UPDATE, 32'hFFFF_FFFF, 1'b1);
        send_branch(KIND_PREDICT, 32'h0000_003F, 1'b0);
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge aclk);

        // random: mostly six hot branches with biased, alternating or random outcomes, rest noise
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
                addr = $urandom();
                if ($urandom_range(0, 3) != 0) begin
                    addr[INDEX_BITS-1:0] = hot[$urandom_range(0, 5)];
                    idx = addr[INDEX_BITS-1:0];
                    case (idx % 4)
                        0: outcome = ($urandom_range(0, 9) != 0);
                        1: outcome = ($urandom_range(0, 9) == 0);
                        2: begin
                            toggle[idx] = ~toggle[idx];
                            outcome = toggle[idx];
                        end
                        default: outcome = 1'($urandom_range(0, 1));
                    endcase
                end else begin
                    outcome = 1'($urandom_range(0, 1));
                end
                kind = 1'($urandom_range(0, 1));
                send_branch(kind, addr, outcome);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        while (tables.predictions_due.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tables.errors == 0)
            $display("** local_two_level_branch_predictor: PASSED **");
        else
            $display("** local_two_level_branch_predictor: FAILED **");
        $finish;
    end

    // receiver: modes switch after random spans, plus one long hold-off
    initial begin
        int  mode;
        int  span;
        int  hold_left;
        int  cyc;
        bit  held;
        mode      = 0;
        span      = 0;
        hold_left = 0;
        cyc       = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (m_tvalid && m_tready)
                tables.check_prediction(m_tdata);
            if (!held && tables.accepted >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 96);
            end
            span--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (cyc % 5 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG) begin
                $display("timeout: no transaction for %0d cycles", idle);
                $display("** local_two_level_branch_predictor: FAILED **");
                $finish;
            end
        end
    end

endmodule
